[rtl/hslrgb_pkg.sv]
// Shared widths, constants and types for the HSL to RGB converter.
package hslrgb_pkg;

    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;
    localparam int CHAN_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int SC_W    = 14;
    localparam int XF_W    = 6;
    localparam int K_W     = 7;
    localparam int LBASE_W = 20;
    localparam int PROD_W  = 22;
    localparam int SUM_W   = 23;
    localparam int NUM_W   = 26;
    localparam int T_W     = 20;
    localparam int RECIP_W = 18;
    localparam int MUL_W   = T_W + RECIP_W;
    localparam int RECIP_SHIFT = 27;
    localparam int PRE_SHIFT   = 6;

    localparam logic [PCT_W-1:0]   SAT_RESET   = 7'd50;
    localparam logic [PCT_W-1:0]   LIGHT_RESET = 7'd80;
    localparam logic [PCT_W-1:0]   PCT_MAX     = 7'd100;
    localparam logic [PCT_W:0]     PCT_HALF_X2 = 8'd100;
    localparam logic [HUE_W-1:0]   HUE_LIMIT   = 9'd360;
    localparam logic [XF_W-1:0]    SECTOR_DEG  = 6'd60;
    localparam logic signed [K_W-1:0] K_HALF   = 7'sd30;
    localparam logic [LBASE_W-1:0] L_SCALE     = 20'd6000;
    localparam logic [NUM_W-1:0]   CHAN_MUL    = 26'd17;
    localparam logic [NUM_W-1:0]   ROUND_BIAS  = 26'd20000;
    localparam logic [RECIP_W-1:0] RECIP_625   = 18'd214749;
    localparam logic [CHAN_W-1:0]  CHAN_MAX    = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAT   = 1'b0,
        REG_LIGHT = 1'b1
    } cfg_reg_e;

    // Hue sector: order of (chroma, second, zero) over red, green, blue
    typedef enum logic [2:0] {
        SEC_RY = 3'd0,
        SEC_YG = 3'd1,
        SEC_GC = 3'd2,
        SEC_CB = 3'd3,
        SEC_BM = 3'd4,
        SEC_MR = 3'd5
    } sector_t;

endpackage

[rtl/hslrgb_if.sv]
// Valid/ready channel interfaces for hue transactions and RGB transactions.
interface hslrgb_hue_if;
    logic                        valid;
    logic                        ready;
    logic [hslrgb_pkg::HUE_W-1:0] hue_deg;

    modport source (output valid, output hue_deg, input ready);
    modport sink   (input valid, input hue_deg, output ready);
endinterface

interface hslrgb_rgb_if;
    logic                         valid;
    logic                         ready;
    logic [hslrgb_pkg::CHAN_W-1:0] red;
    logic [hslrgb_pkg::CHAN_W-1:0] green;
    logic [hslrgb_pkg::CHAN_W-1:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

[rtl/hslrgb_chan.sv]
// One colour channel: scaled offset product, rounding sum and reciprocal divide.
module hslrgb_chan (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic [hslrgb_pkg::SC_W-1:0]           sc,
    input  logic signed [hslrgb_pkg::K_W-1:0]     k,
    input  logic [hslrgb_pkg::LBASE_W-1:0]        lbase,
    output logic [hslrgb_pkg::CHAN_W-1:0]         level
);

    localparam int RECIP_SHIFT_L = hslrgb_pkg::RECIP_SHIFT;

    logic signed [hslrgb_pkg::PROD_W-1:0] p_reg;
    logic signed [hslrgb_pkg::PROD_W-1:0] p_next;
    logic [hslrgb_pkg::T_W-1:0]           t_reg;
    logic [hslrgb_pkg::T_W-1:0]           t_next;
    logic signed [hslrgb_pkg::SUM_W-1:0]  v_sum;
    logic [hslrgb_pkg::NUM_W-1:0]         n_val;
    logic [hslrgb_pkg::MUL_W-1:0]         prod;
    logic [hslrgb_pkg::MUL_W-RECIP_SHIFT_L-1:0] q_wide;

    assign p_next = $signed({1'b0, sc}) * k;

    assign v_sum = $signed({3'b000, lbase}) + $signed({p_reg[hslrgb_pkg::PROD_W-1], p_reg});
    assign n_val = {5'b00000, v_sum[20:0]} * hslrgb_pkg::CHAN_MUL + hslrgb_pkg::ROUND_BIAS;
    assign t_next = v_sum[hslrgb_pkg::SUM_W-1] ? '0
                  : n_val[hslrgb_pkg::NUM_W-1:hslrgb_pkg::PRE_SHIFT];

    assign prod   = {{hslrgb_pkg::RECIP_W{1'b0}}, t_reg}
                  * {{hslrgb_pkg::T_W{1'b0}}, hslrgb_pkg::RECIP_625};
    assign q_wide = prod[hslrgb_pkg::MUL_W-1:RECIP_SHIFT_L];
    assign level  = (q_wide > {3'b000, hslrgb_pkg::CHAN_MAX}) ? hslrgb_pkg::CHAN_MAX
                  : q_wide[hslrgb_pkg::CHAN_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
            t_reg <= t_next;
        end
    end

endmodule

[rtl/hsl_to_rgb_converter_top.sv]
// Top level of the HSL to RGB converter: hue pipeline, configuration and output register.
//
// Usage:
//   hue_in  : sink of hue transactions (hue_deg, whole degrees; 360 and above give black).
//   rgb_out : source of RGB transactions (red, green, blue), one per hue, in order.
//   cfg_we/cfg_idx/cfg_data : write saturation (index 0) and lightness (index 1)
//   in percent; values above 100 act as 100. Write only while the block is idle.
// Throughput: one transaction per clock; a hue enters in every cycle that the
// output side accepts or the output register is empty.
// Pipeline: a hue accepted on hue_in goes through hue decode, offset products,
// rounding sum and reciprocal divide into the output register, which drives rgb_out.
// Stall: when rgb_out.ready is low with a result waiting, every stage holds and
// hue_in.ready drops; nothing is lost or repeated.
// Reset: valid bits clear, saturation returns to 50 and lightness to 80.
module hsl_to_rgb_converter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hslrgb_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  logic [hslrgb_pkg::PCT_W-1:0]        cfg_data,
    hslrgb_hue_if.sink                          hue_in,
    hslrgb_rgb_if.source                        rgb_out
);

    logic [hslrgb_pkg::PCT_W-1:0] sat_reg;
    logic [hslrgb_pkg::PCT_W-1:0] light_reg;

    logic en;
    logic v1_reg, v2_reg, v3_reg, out_valid_reg;
    logic black1_reg, black2_reg, black3_reg;

    logic [hslrgb_pkg::PCT_W-1:0]   s_cl, l_cl;
    logic [hslrgb_pkg::PCT_W:0]     l_x2;
    logic [hslrgb_pkg::PCT_W-1:0]   cn;
    logic [hslrgb_pkg::HUE_W-1:0]   rem;
    logic                           odd;
    hslrgb_pkg::sector_t            sector_next;
    logic [hslrgb_pkg::XF_W-1:0]    xf_next;
    logic [hslrgb_pkg::SC_W-1:0]    sc_next;

    hslrgb_pkg::sector_t            sector1_reg;
    logic [hslrgb_pkg::XF_W-1:0]    xf1_reg;
    logic [hslrgb_pkg::SC_W-1:0]    sc1_reg;
    logic [hslrgb_pkg::PCT_W-1:0]   l1_reg;
    logic [hslrgb_pkg::LBASE_W-1:0] lbase2_reg;
    logic [hslrgb_pkg::LBASE_W-1:0] lbase2_next;

    logic signed [hslrgb_pkg::K_W-1:0] kx, kz, k_r, k_g, k_b;
    logic [hslrgb_pkg::CHAN_W-1:0] lev_r, lev_g, lev_b;
    logic [hslrgb_pkg::CHAN_W-1:0] red_reg, green_reg, blue_reg;

    assign en           = !out_valid_reg || rgb_out.ready;
    assign hue_in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sat_reg   <= hslrgb_pkg::SAT_RESET;
            light_reg <= hslrgb_pkg::LIGHT_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_idx == hslrgb_pkg::REG_SAT)
                sat_reg <= cfg_data;
            else
                light_reg <= cfg_data;
        end
    end

    // Decode hue and lightness term
    assign s_cl = (sat_reg > hslrgb_pkg::PCT_MAX) ? hslrgb_pkg::PCT_MAX : sat_reg;
    assign l_cl = (light_reg > hslrgb_pkg::PCT_MAX) ? hslrgb_pkg::PCT_MAX : light_reg;
    assign l_x2 = {l_cl, 1'b0};
    assign cn   = (l_x2 >= hslrgb_pkg::PCT_HALF_X2)
                ? 7'(9'd200 - {1'b0, l_x2})
                : l_x2[hslrgb_pkg::PCT_W-1:0];
    assign sc_next = 14'(s_cl) * 14'(cn);

    always_comb
    begin
        priority if (hue_in.hue_deg < 9'd60)
        begin
            sector_next = hslrgb_pkg::SEC_RY;
            rem         = hue_in.hue_deg;
        end
        else if (hue_in.hue_deg < 9'd120)
        begin
            sector_next = hslrgb_pkg::SEC_YG;
            rem         = hue_in.hue_deg - 9'd60;
        end
        else if (hue_in.hue_deg < 9'd180)
        begin
            sector_next = hslrgb_pkg::SEC_GC;
            rem         = hue_in.hue_deg - 9'd120;
        end
        else if (hue_in.hue_deg < 9'd240)
        begin
            sector_next = hslrgb_pkg::SEC_CB;
            rem         = hue_in.hue_deg - 9'd180;
        end
        else if (hue_in.hue_deg < 9'd300)
        begin
            sector_next = hslrgb_pkg::SEC_BM;
            rem         = hue_in.hue_deg - 9'd240;
        end
        else
        begin
            sector_next = hslrgb_pkg::SEC_MR;
            rem         = hue_in.hue_deg - 9'd300;
        end
    end

    assign odd     = (sector_next == hslrgb_pkg::SEC_YG) || (sector_next == hslrgb_pkg::SEC_CB)
                  || (sector_next == hslrgb_pkg::SEC_MR);
    assign xf_next = odd ? (hslrgb_pkg::SECTOR_DEG - rem[hslrgb_pkg::XF_W-1:0])
                         : rem[hslrgb_pkg::XF_W-1:0];

    // Offset factor per channel: chroma +30, second xf-30, zero -30
    assign kx = $signed({1'b0, xf1_reg}) - hslrgb_pkg::K_HALF;
    assign kz = -hslrgb_pkg::K_HALF;

    always_comb
    begin
        unique case (sector1_reg)
            hslrgb_pkg::SEC_RY: begin k_r = hslrgb_pkg::K_HALF; k_g = kx; k_b = kz; end
            hslrgb_pkg::SEC_YG: begin k_r = kx; k_g = hslrgb_pkg::K_HALF; k_b = kz; end
            hslrgb_pkg::SEC_GC: begin k_r = kz; k_g = hslrgb_pkg::K_HALF; k_b = kx; end
            hslrgb_pkg::SEC_CB: begin k_r = kz; k_g = kx; k_b = hslrgb_pkg::K_HALF; end
            hslrgb_pkg::SEC_BM: begin k_r = kx; k_g = kz; k_b = hslrgb_pkg::K_HALF; end
            default:            begin k_r = hslrgb_pkg::K_HALF; k_g = kz; k_b = kx; end
        endcase
    end

    assign lbase2_next = 20'(l1_reg) * hslrgb_pkg::L_SCALE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= hue_in.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sector1_reg <= sector_next;
            xf1_reg     <= xf_next;
            sc1_reg     <= sc_next;
            l1_reg      <= l_cl;
            black1_reg  <= (hue_in.hue_deg >= hslrgb_pkg::HUE_LIMIT);
            lbase2_reg  <= lbase2_next;
            black2_reg  <= black1_reg;
            black3_reg  <= black2_reg;
            red_reg     <= black3_reg ? '0 : lev_r;
            green_reg   <= black3_reg ? '0 : lev_g;
            blue_reg    <= black3_reg ? '0 : lev_b;
        end
    end

    hslrgb_chan u_chan_r (
        .clk   (clk),
        .en    (en),
        .sc    (sc1_reg),
        .k     (k_r),
        .lbase (lbase2_reg),
        .level (lev_r)
    );

    hslrgb_chan u_chan_g (
        .clk   (clk),
        .en    (en),
        .sc    (sc1_reg),
        .k     (k_g),
        .lbase (lbase2_reg),
        .level (lev_g)
    );

    hslrgb_chan u_chan_b (
        .clk   (clk),
        .en    (en),
        .sc    (sc1_reg),
        .k     (k_b),
        .lbase (lbase2_reg),
        .level (lev_b)
    );

    assign rgb_out.valid = out_valid_reg;
    assign rgb_out.red   = red_reg;
    assign rgb_out.green = green_reg;
    assign rgb_out.blue  = blue_reg;

endmodule
